@@ rtl/masbox_pkg.sv @@
// Types, share-count codes and S-box step functions for the masked Ascon S-box slice.
// No dependencies; used by masked_ascon_sbox_slice_top.

package masbox_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [1:0] pair_t;    // [0] = share 0, [1] = share 1
	typedef pair_t [5:0] slice_t;   // lanes 0..4 and scratch lane 5

	// Active-share codes after saturation
	typedef enum logic [1:0] {
		SHARES_NONE = 2'd0,
		SHARES_ONE  = 2'd1,
		SHARES_TWO  = 2'd2
	} shares_t;

	localparam logic [1:0] SHARE_COUNT_RESET = 2'd2;
	localparam logic [1:0] SHARE_COUNT_SAT   = 2'd3;

	// Cross-share rotations: 5 * (index difference) mod 32
	localparam logic [4:0] ROT_NEG = 5'd27;
	localparam logic [4:0] ROT_POS = 5'd5;

	// Rotate right by a 5-bit amount
	function automatic word_t ror32(input word_t v, input logic [4:0] n);
		logic [5:0] inv;
		inv = 6'd32 - {1'b0, n};
		return (v >> n) | (v << inv);
	endfunction

	// Masked Toffoli gate: c ^= a AND NOT b over the active shares
	function automatic pair_t toffoli(input pair_t c, input pair_t a, input pair_t b,
		input shares_t act);
		pair_t r;
		r = c;
		case (act)
			SHARES_ONE: begin
				r[0] = c[0] ^ (a[0] & ~b[0]);
			end
			SHARES_TWO: begin
				r[0] = c[0] ^ (a[0] & ~b[0]) ^ (a[0] & ror32(b[1], ROT_POS));
				r[1] = c[1] ^ (a[1] & ~ror32(b[0], ROT_NEG)) ^ (a[1] & b[1]);
			end
			default: begin
				r = c;
			end
		endcase
		return r;
	endfunction

	// First affine layer on one share
	function automatic slice_t affine_first(input slice_t x, input logic d);
		slice_t r;
		r = x;
		r[2][d] = r[2][d] ^ r[1][d];
		r[0][d] = r[0][d] ^ r[4][d];
		r[4][d] = r[4][d] ^ r[3][d];
		return r;
	endfunction

	// Second affine layer on one share
	function automatic slice_t affine_second(input slice_t x, input logic d);
		slice_t r;
		r = x;
		r[2][d] = r[2][d] ^ r[5][d];
		r[1][d] = r[1][d] ^ r[0][d];
		r[0][d] = r[0][d] ^ r[4][d];
		r[3][d] = r[3][d] ^ r[2][d];
		return r;
	endfunction

endpackage

@@ rtl/masked_ascon_sbox_slice_top.sv @@
// Masked Ascon S-box on one 32-bit bit-interleaved slice of six two-share lanes.
// Depends on masbox_pkg (types, share codes, gate and affine functions).
//
// Usage:
//   Input channel (in_valid/in_ready) carries twelve 32-bit words: lanes 0..4
//   and the scratch lane, two shares each. Output channel (out_valid/out_ready)
//   returns the same twelve words after the S-box, one result per input.
//   Config channel (cfg_valid/cfg_ready) writes share_count: 1 unmasked,
//   2 two-share, 3 acts as 2, 0 leaves everything but the lane 2 share 0
//   inversion untouched. cfg_ready is always high; write only while idle.
// Pipeline and throughput:
//   An input register, then the S-box logic into the result register, from
//   which the result transfers. One item per cycle sustained while out_ready
//   stays high.
// Reset:
//   arst_n clears both valid flags and sets share_count to 2.
// Stall:
//   While out_ready is low the result holds; one more item can sit in the
//   input register, after which in_ready drops until the result is taken.

module masked_ascon_sbox_slice_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  masbox_pkg::word_t   lane0_share0,
	input  masbox_pkg::word_t   lane0_share1,
	input  masbox_pkg::word_t   lane1_share0,
	input  masbox_pkg::word_t   lane1_share1,
	input  masbox_pkg::word_t   lane2_share0,
	input  masbox_pkg::word_t   lane2_share1,
	input  masbox_pkg::word_t   lane3_share0,
	input  masbox_pkg::word_t   lane3_share1,
	input  masbox_pkg::word_t   lane4_share0,
	input  masbox_pkg::word_t   lane4_share1,
	input  masbox_pkg::word_t   scratch_share0,
	input  masbox_pkg::word_t   scratch_share1,
	output logic                out_valid,
	input  logic                out_ready,
	output masbox_pkg::word_t   out_lane0_share0,
	output masbox_pkg::word_t   out_lane0_share1,
	output masbox_pkg::word_t   out_lane1_share0,
	output masbox_pkg::word_t   out_lane1_share1,
	output masbox_pkg::word_t   out_lane2_share0,
	output masbox_pkg::word_t   out_lane2_share1,
	output masbox_pkg::word_t   out_lane3_share0,
	output masbox_pkg::word_t   out_lane3_share1,
	output masbox_pkg::word_t   out_lane4_share0,
	output masbox_pkg::word_t   out_lane4_share1,
	output masbox_pkg::word_t   out_scratch_share0,
	output masbox_pkg::word_t   out_scratch_share1
);

	import masbox_pkg::*;

	logic [1:0] share_count_q;
	shares_t    act;

	logic       valid_s1;
	slice_t     data_s1;
	logic       valid_q;
	slice_t     result_q;
	slice_t     sbox;
	logic       adv_out;
	logic       adv_in;

	// Config register: always ready, written on transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			share_count_q <= SHARE_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			share_count_q <= cfg_data;
		end
	end

	// Saturate share count three to two shares
	always_comb begin
		case (share_count_q)
			SHARE_COUNT_SAT: act = SHARES_TWO;
			default:         act = shares_t'(share_count_q);
		endcase
	end

	// Handshake: result register frees when empty or taken
	assign adv_out   = !valid_q || out_ready;
	assign adv_in    = !valid_s1 || adv_out;
	assign in_ready  = adv_in;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (adv_in) begin
				valid_s1 <= in_valid;
			end
			if (adv_out) begin
				valid_q <= valid_s1;
			end
		end
	end

	// Capture input words on transfer
	always_ff @(posedge clk) begin
		if (in_valid && adv_in) begin
			data_s1[0] <= {lane0_share1, lane0_share0};
			data_s1[1] <= {lane1_share1, lane1_share0};
			data_s1[2] <= {lane2_share1, lane2_share0};
			data_s1[3] <= {lane3_share1, lane3_share0};
			data_s1[4] <= {lane4_share1, lane4_share0};
			data_s1[5] <= {scratch_share1, scratch_share0};
		end
	end

	// S-box: affine, five Toffoli gates, affine, invert lane 2 share 0
	always_comb begin
		slice_t x;
		x = data_s1;
		if (act == SHARES_ONE || act == SHARES_TWO) begin
			x = affine_first(x, 1'b0);
		end
		if (act == SHARES_TWO) begin
			x = affine_first(x, 1'b1);
		end
		x[5] = toffoli(x[5], x[4], x[3], act);
		x[4] = toffoli(x[4], x[1], x[0], act);
		x[1] = toffoli(x[1], x[3], x[2], act);
		x[3] = toffoli(x[3], x[0], x[4], act);
		x[0] = toffoli(x[0], x[2], x[1], act);
		if (act == SHARES_ONE || act == SHARES_TWO) begin
			x = affine_second(x, 1'b0);
		end
		x[2][0] = ~x[2][0];
		if (act == SHARES_TWO) begin
			x = affine_second(x, 1'b1);
		end
		sbox = x;
	end

	// Load result register when it advances
	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			result_q <= sbox;
		end
	end

	assign out_lane0_share0   = result_q[0][0];
	assign out_lane0_share1   = result_q[0][1];
	assign out_lane1_share0   = result_q[1][0];
	assign out_lane1_share1   = result_q[1][1];
	assign out_lane2_share0   = result_q[2][0];
	assign out_lane2_share1   = result_q[2][1];
	assign out_lane3_share0   = result_q[3][0];
	assign out_lane3_share1   = result_q[3][1];
	assign out_lane4_share0   = result_q[4][0];
	assign out_lane4_share1   = result_q[4][1];
	assign out_scratch_share0 = result_q[5][0];
	assign out_scratch_share1 = result_q[5][1];

endmodule

@@ bench/tb_masked_ascon_sbox_slice_top.sv @@
// Self-checking bench for masked_ascon_sbox_slice_top: random and directed slices
// under every share count, with a clocked driver, monitor and S-box predictor.
// Depends on masbox_pkg and the masked_ascon_sbox_slice_top RTL.
`timescale 1ns / 100ps

module tb_masked_ascon_sbox_slice_top;

	import masbox_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int PHASES     = 5;

	typedef enum {PAT_ZERO, PAT_ONES, PAT_SPLIT, PAT_STRIPES} pattern_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_valid = 1'b0;
	logic [1:0] cfg_data  = '0;
	logic       in_valid  = 1'b0;
	logic       out_ready = 1'b0;
	slice_t     send_slice = '0;
	logic       cfg_ready;
	logic       in_ready;
	logic       out_valid;
	wire [31:0] got_word [0:11];

	slice_t     pending_slices [$];
	slice_t     expected_slices [$];
	slice_t     cur_slice;
	logic [1:0] share_count_now = SHARE_COUNT_RESET;
	int         in_gap = 0;
	int         out_hold = 0;
	int         calm_in = 0;
	int         calm_out = 0;
	int         idle_cycles = 0;
	int         failures = 0;
	int         slices_sent = 0;
	int         slices_checked = 0;

	string field_name [12] = '{
		"out_lane0_share0", "out_lane0_share1", "out_lane1_share0", "out_lane1_share1",
		"out_lane2_share0", "out_lane2_share1", "out_lane3_share0", "out_lane3_share1",
		"out_lane4_share0", "out_lane4_share1", "out_scratch_share0", "out_scratch_share1"
	};

	masked_ascon_sbox_slice_top DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.lane0_share0       (send_slice[0][0]),
		.lane0_share1       (send_slice[0][1]),
		.lane1_share0       (send_slice[1][0]),
		.lane1_share1       (send_slice[1][1]),
		.lane2_share0       (send_slice[2][0]),
		.lane2_share1       (send_slice[2][1]),
		.lane3_share0       (send_slice[3][0]),
		.lane3_share1       (send_slice[3][1]),
		.lane4_share0       (send_slice[4][0]),
		.lane4_share1       (send_slice[4][1]),
		.scratch_share0     (send_slice[5][0]),
		.scratch_share1     (send_slice[5][1]),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.out_lane0_share0   (got_word[0]),
		.out_lane0_share1   (got_word[1]),
		.out_lane1_share0   (got_word[2]),
		.out_lane1_share1   (got_word[3]),
		.out_lane2_share0   (got_word[4]),
		.out_lane2_share1   (got_word[5]),
		.out_lane3_share0   (got_word[6]),
		.out_lane3_share1   (got_word[7]),
		.out_lane4_share0   (got_word[8]),
		.out_lane4_share1   (got_word[9]),
		.out_scratch_share0 (got_word[10]),
		.out_scratch_share1 (got_word[11])
	);

	always #10 clk = ~clk;

	// c ^= a AND NOT b; each share sees its partner rotated right, share 0 by 5 and share 1 by 27
	function automatic pair_t gate_and_not(input pair_t c, input pair_t a, input pair_t b,
		input shares_t act);
		pair_t r;
		r = c;
		if (act == SHARES_ONE) begin
			r[0] = c[0] ^ (a[0] & ~b[0]);
		end else if (act == SHARES_TWO) begin
			r[0] = c[0] ^ (a[0] & ~b[0]) ^ (a[0] & {b[1][4:0], b[1][31:5]});
			r[1] = c[1] ^ (a[1] & ~{b[0][26:0], b[0][31:27]}) ^ (a[1] & b[1]);
		end
		return r;
	endfunction

	function automatic slice_t linear_in(input slice_t x, input int d);
		slice_t r;
		r = x;
		r[2][d] = r[2][d] ^ r[1][d];
		r[0][d] = r[0][d] ^ r[4][d];
		r[4][d] = r[4][d] ^ r[3][d];
		return r;
	endfunction

	function automatic slice_t linear_out(input slice_t x, input int d);
		slice_t r;
		r = x;
		r[2][d] = r[2][d] ^ r[5][d];
		r[1][d] = r[1][d] ^ r[0][d];
		r[0][d] = r[0][d] ^ r[4][d];
		r[3][d] = r[3][d] ^ r[2][d];
		return r;
	endfunction

	// Full masked S-box on one slice under the given share count
	function automatic slice_t sbox_slice_predict(input slice_t s, input logic [1:0] cnt);
		slice_t x;
		shares_t act;
		x = s;
		act = (cnt == SHARE_COUNT_SAT) ? SHARES_TWO : shares_t'(cnt);
		if (act != SHARES_NONE) x = linear_in(x, 0);
		if (act == SHARES_TWO) x = linear_in(x, 1);
		x[5] = gate_and_not(x[5], x[4], x[3], act);
		x[4] = gate_and_not(x[4], x[1], x[0], act);
		x[1] = gate_and_not(x[1], x[3], x[2], act);
		x[3] = gate_and_not(x[3], x[0], x[4], act);
		x[0] = gate_and_not(x[0], x[2], x[1], act);
		if (act != SHARES_NONE) x = linear_out(x, 0);
		x[2][0] = ~x[2][0];
		if (act == SHARES_TWO) x = linear_out(x, 1);
		return x;
	endfunction

	// Mostly short pauses, a few long ones, and now and then a calm stretch with none
	function automatic int pause_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic slice_t pattern_slice(input pattern_t kind);
		slice_t s;
		for (int l = 0; l < 6; l++) begin
			case (kind)
				PAT_ZERO:  s[l] = '0;
				PAT_ONES:  s[l] = '1;
				PAT_SPLIT: begin
					s[l][0] = '1;
					s[l][1] = '0;
				end
				default: begin
					s[l][0] = l[0] ? 32'hAAAA_AAAA : 32'h5555_5555;
					s[l][1] = l[0] ? 32'h5555_5555 : 32'hAAAA_AAAA;
				end
			endcase
		end
		return s;
	endfunction

	// Random words, sometimes thinned or filled to shift the AND terms
	function automatic slice_t random_slice();
		slice_t s;
		int mode;
		mode = $urandom_range(0, 9);
		for (int l = 0; l < 6; l++) begin
			for (int d = 0; d < 2; d++) begin
				s[l][d] = $urandom;
				if (mode == 8) s[l][d] = s[l][d] & $urandom & $urandom;
				if (mode == 9) s[l][d] = s[l][d] | $urandom | $urandom;
			end
		end
		return s;
	endfunction

	// Write share_count; the mirror follows at the transfer edge
	task automatic write_share_count(input logic [1:0] cnt);
		cfg_data  <= cnt;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		share_count_now = cnt;
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_slices.size() != 0 || in_valid || expected_slices.size() != 0)
			@(posedge clk);
	endtask

	// Input driver: predict on transfer, then load the next slice or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			send_slice <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_slices.push_back(sbox_slice_predict(cur_slice, share_count_now));
				slices_sent++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_slices.size() != 0) begin
					cur_slice = pending_slices.pop_front();
					send_slice <= cur_slice;
					in_valid <= 1'b1;
					in_gap = pause_len(calm_in);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output stall generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_hold > 0) begin
			out_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			out_hold = pause_len(calm_out);
		end
	end

	// Monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		slice_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_slices.size() == 0) begin
				$error("result transfer with no slice outstanding");
				failures++;
			end else begin
				want = expected_slices.pop_front();
				slices_checked++;
				for (int i = 0; i < 12; i++) begin
					if (got_word[i] !== want[i / 2][i % 2]) begin
						$error("%s expected %08h got %08h", field_name[i],
							want[i / 2][i % 2], got_word[i]);
						failures++;
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("FAIL masked_ascon_sbox_slice_top");
				$finish;
			end
		end
	end

	initial begin
		logic [1:0] phase_count [PHASES];
		int         phase_items [PHASES];
		phase_count = '{SHARE_COUNT_RESET, SHARES_ONE, SHARES_NONE, SHARE_COUNT_SAT, SHARES_TWO};
		phase_items = '{500, 400, 120, 180, 130};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < PHASES; p++) begin
			write_share_count(phase_count[p]);
			for (int k = PAT_ZERO; k <= PAT_STRIPES; k++)
				pending_slices.push_back(pattern_slice(pattern_t'(k)));
			for (int n = 0; n < phase_items[p]; n++)
				pending_slices.push_back(random_slice());
			wait_drained();
		end
		repeat (6) @(posedge clk);
		if (expected_slices.size() != 0) begin
			$error("%0d expected results never arrived", expected_slices.size());
			failures++;
		end
		$display("sent %0d slices, checked %0d results", slices_sent, slices_checked);
		$display("share counts 2, 1, 0, 3, 2 with random input and output stalls");
		if (failures == 0)
			$display("PASS masked_ascon_sbox_slice_top");
		else
			$display("FAIL masked_ascon_sbox_slice_top");
		$finish;
	end

endmodule
